// ===== rtl/copq_pkg.sv =====
package copq_pkg;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] handle;
    logic       is_announce;
    logic       is_mission;
    logic       is_header;
    logic [3:0] position;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_handle;
    logic [4:0] occupancy;
    logic       last;
  } res_item_t;

  localparam logic [1:0] FN_ENQ   = 2'd0;
  localparam logic [1:0] FN_DEQ   = 2'd1;
  localparam logic [1:0] FN_RMPOS = 2'd2;
  localparam logic [1:0] FN_RMH   = 2'd3;

  localparam logic [2:0] K_ENQUEUED  = 3'd0;
  localparam logic [2:0] K_DISCARDED = 3'd1;
  localparam logic [2:0] K_DROPPED   = 3'd2;
  localparam logic [2:0] K_DEQUEUED  = 3'd3;
  localparam logic [2:0] K_EMPTY     = 3'd4;
  localparam logic [2:0] K_REMOVED   = 3'd5;
  localparam logic [2:0] K_FULL      = 3'd6;
  localparam logic [2:0] K_IGNORED   = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_CP_RD,
    ST_CP_WR,
    ST_FINAL
  } state_t;

endpackage

// ===== rtl/copq_mem.sv =====
module copq_mem import copq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/class_ordered_packet_queue_unit.sv =====
// Class-ordered packet queue. Entries live in two ping-pong memories: each
// operation first scans the current bank (one read a cycle), decides, then
// copies the new layout into the other bank, reading and then writing each held
// entry and writing an inserted item in its place, and swaps banks. A new item
// is accepted only in the idle state, after the copy and any final result; the
// single read port and the read-then-write copy set the pace. Results are
// delivered through an output register, and the copy and the final result wait
// only while the output is stalled.
module class_ordered_packet_queue_unit import copq_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int HANDLE_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output res_item_t out_data
);

  localparam int HB = HANDLE_BITS;
  localparam int EW = HB + 3;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 4) ? CW : 4;

  state_t state_r, state_nxt;
  logic cur_r, cur_nxt;
  logic [CW-1:0] fill_r, fill_nxt;

  logic [1:0] func_r, func_nxt;
  logic [HB-1:0] h_r, h_nxt;
  logic ann_r, ann_nxt, mis_r, mis_nxt, hdr_r, hdr_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [CW-1:0] pidx_r, pidx_nxt;

  logic [CW-1:0] si_r, si_nxt, rj_r, rj_nxt;
  logic rv_r, rv_nxt;
  logic ann_any_r, ann_any_nxt, hf_r, hf_nxt;
  logic [CW-1:0] hdr_first_r, hdr_first_nxt;
  logic fnh_found_r, fnh_found_nxt, in_run_r, in_run_nxt;
  logic [CW-1:0] fnh_r, fnh_nxt, run_end_r, run_end_nxt;
  logic fr_found_r, fr_found_nxt;
  logic [CW-1:0] after_r, after_nxt, match_r, match_nxt;
  logic [HB-1:0] posh_r, posh_nxt;

  logic ins_pend_r, ins_pend_nxt;
  logic [CW-1:0] ins_src_r, ins_src_nxt, dlo_r, dlo_nxt, dhi_r, dhi_nxt;
  logic rmh_r, rmh_nxt, emit_r, emit_nxt, has_fin_r, has_fin_nxt;
  logic [2:0] fin_kind_r, fin_kind_nxt;
  logic [7:0] fin_h_r, fin_h_nxt;
  logic [CW-1:0] occ_r, occ_nxt, dleft_r, dleft_nxt;
  logic [CW-1:0] ci_r, ci_nxt, wi_r, wi_nxt;

  logic out_valid_r, out_valid_nxt;
  res_item_t out_r, out_nxt;

  logic rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data, rd0, rd1, rd_data;
  logic [HB-1:0] dh;
  logic da, dm, dd, full, drop;

  copq_mem #(.DEPTH(DEPTH), .WIDTH(EW)) u_bank0 (
    .clk(clk), .we(wr_en && cur_r), .waddr(wr_addr), .wdata(wr_data),
    .re(rd_en && !cur_r), .raddr(rd_addr), .rdata(rd0)
  );

  copq_mem #(.DEPTH(DEPTH), .WIDTH(EW)) u_bank1 (
    .clk(clk), .we(wr_en && !cur_r), .waddr(wr_addr), .wdata(wr_data),
    .re(rd_en && cur_r), .raddr(rd_addr), .rdata(rd1)
  );

  assign rd_data   = cur_r ? rd1 : rd0;
  assign dh        = rd_data[HB-1:0];
  assign da        = rd_data[HB];
  assign dm        = rd_data[HB+1];
  assign dd        = rd_data[HB+2];
  assign full      = (fill_r == CW'(DEPTH));
  assign drop      = (ci_r >= dlo_r && ci_r < dhi_r) || (rmh_r && dh == h_r);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      rv_r        <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt; h_r <= h_nxt; ann_r <= ann_nxt; mis_r <= mis_nxt;
    hdr_r <= hdr_nxt; pos_r <= pos_nxt; pidx_r <= pidx_nxt;
    si_r <= si_nxt; rj_r <= rj_nxt;
    ann_any_r <= ann_any_nxt; hf_r <= hf_nxt; hdr_first_r <= hdr_first_nxt;
    fnh_found_r <= fnh_found_nxt; in_run_r <= in_run_nxt; fnh_r <= fnh_nxt;
    run_end_r <= run_end_nxt; fr_found_r <= fr_found_nxt; after_r <= after_nxt;
    match_r <= match_nxt; posh_r <= posh_nxt;
    ins_pend_r <= ins_pend_nxt; ins_src_r <= ins_src_nxt;
    dlo_r <= dlo_nxt; dhi_r <= dhi_nxt; rmh_r <= rmh_nxt; emit_r <= emit_nxt;
    has_fin_r <= has_fin_nxt; fin_kind_r <= fin_kind_nxt; fin_h_r <= fin_h_nxt;
    occ_r <= occ_nxt; dleft_r <= dleft_nxt; ci_r <= ci_nxt; wi_r <= wi_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r; cur_nxt = cur_r; fill_nxt = fill_r;
    func_nxt = func_r; h_nxt = h_r; ann_nxt = ann_r; mis_nxt = mis_r;
    hdr_nxt = hdr_r; pos_nxt = pos_r; pidx_nxt = pidx_r;
    si_nxt = si_r; rj_nxt = rj_r; rv_nxt = 1'b0;
    ann_any_nxt = ann_any_r; hf_nxt = hf_r; hdr_first_nxt = hdr_first_r;
    fnh_found_nxt = fnh_found_r; in_run_nxt = in_run_r; fnh_nxt = fnh_r;
    run_end_nxt = run_end_r; fr_found_nxt = fr_found_r; after_nxt = after_r;
    match_nxt = match_r; posh_nxt = posh_r;
    ins_pend_nxt = ins_pend_r; ins_src_nxt = ins_src_r;
    dlo_nxt = dlo_r; dhi_nxt = dhi_r; rmh_nxt = rmh_r; emit_nxt = emit_r;
    has_fin_nxt = has_fin_r; fin_kind_nxt = fin_kind_r; fin_h_nxt = fin_h_r;
    occ_nxt = occ_r; dleft_nxt = dleft_r; ci_nxt = ci_r; wi_nxt = wi_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt = out_r;
    rd_en = 1'b0; rd_addr = '0;
    wr_en = 1'b0; wr_addr = wi_r[AW-1:0]; wr_data = rd_data;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt = in_data.func;
          h_nxt = HB'(in_data.handle);
          ann_nxt = in_data.is_announce;
          mis_nxt = in_data.is_mission;
          hdr_nxt = in_data.is_header;
          pos_nxt = in_data.position;
          pidx_nxt = (in_data.func == FN_DEQ) ? '0 : CW'(in_data.position);
          si_nxt = '0;
          ann_any_nxt = 1'b0; hf_nxt = 1'b0; hdr_first_nxt = fill_r;
          fnh_found_nxt = 1'b0; in_run_nxt = 1'b0; fnh_nxt = '0;
          run_end_nxt = fill_r; fr_found_nxt = 1'b0; after_nxt = '0;
          match_nxt = '0; posh_nxt = '0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (si_r < fill_r) begin
          rd_en = 1'b1;
          rd_addr = si_r[AW-1:0];
          si_nxt = si_r + CW'(1);
          rj_nxt = si_r;
          rv_nxt = 1'b1;
        end else if (!rv_r) begin
          state_nxt = ST_DECIDE;
        end
        if (rv_r) begin
          if (da) ann_any_nxt = 1'b1;
          if (dd && !hf_r) begin
            hf_nxt = 1'b1;
            hdr_first_nxt = rj_r;
          end
          if (!dm && dd && !fnh_found_r) begin
            fnh_found_nxt = 1'b1;
            fnh_nxt = rj_r;
            in_run_nxt = 1'b1;
          end else if (in_run_r && dm) begin
            run_end_nxt = rj_r;
            in_run_nxt = 1'b0;
          end
          if (!dm && dd) begin
            fr_found_nxt = 1'b1;
            after_nxt = rj_r;
          end else if (fr_found_r && !dm) begin
            after_nxt = rj_r;
          end
          if (dh == h_r) match_nxt = match_r + CW'(1);
          if (rj_r == pidx_r) posh_nxt = dh;
        end
      end

      ST_DECIDE: begin
        ins_pend_nxt = 1'b0; ins_src_nxt = '0;
        dlo_nxt = '0; dhi_nxt = '0; rmh_nxt = 1'b0; emit_nxt = 1'b0;
        has_fin_nxt = 1'b1; fin_kind_nxt = K_ENQUEUED; fin_h_nxt = 8'(h_r);
        occ_nxt = fill_r; dleft_nxt = '0; ci_nxt = '0; wi_nxt = '0;
        state_nxt = ST_FINAL;
        case (func_r)
          FN_ENQ: begin
            if (ann_r && ann_any_r) begin
              fin_kind_nxt = K_DISCARDED;
            end else if (!mis_r && !ann_r && hdr_r && fnh_found_r) begin
              ins_pend_nxt = 1'b1;
              ins_src_nxt = run_end_r;
              dlo_nxt = fnh_r;
              dhi_nxt = run_end_r;
              emit_nxt = 1'b1;
              dleft_nxt = run_end_r - fnh_r;
              occ_nxt = fill_r - (run_end_r - fnh_r) + CW'(1);
              state_nxt = ST_CP_RD;
            end else if (full) begin
              fin_kind_nxt = K_FULL;
            end else begin
              ins_pend_nxt = 1'b1;
              occ_nxt = fill_r + CW'(1);
              if (ann_r) ins_src_nxt = hdr_first_r;
              else if (mis_r || hdr_r) ins_src_nxt = fill_r;
              else ins_src_nxt = fr_found_r ? after_r + CW'(1) : '0;
              state_nxt = ST_CP_RD;
            end
          end
          FN_DEQ: begin
            if (fill_r == '0) begin
              fin_kind_nxt = K_EMPTY;
              fin_h_nxt = '0;
            end else begin
              fin_kind_nxt = K_DEQUEUED;
              fin_h_nxt = 8'(posh_r);
              dlo_nxt = '0;
              dhi_nxt = CW'(1);
              occ_nxt = fill_r - CW'(1);
              state_nxt = ST_CP_RD;
            end
          end
          FN_RMPOS: begin
            if (PW'(pos_r) >= PW'(fill_r)) begin
              fin_kind_nxt = K_IGNORED;
              fin_h_nxt = '0;
            end else begin
              fin_kind_nxt = K_REMOVED;
              fin_h_nxt = 8'(posh_r);
              dlo_nxt = pidx_r;
              dhi_nxt = pidx_r + CW'(1);
              occ_nxt = fill_r - CW'(1);
              state_nxt = ST_CP_RD;
            end
          end
          default: begin
            if (match_r == '0) begin
              fin_kind_nxt = K_IGNORED;
            end else begin
              has_fin_nxt = 1'b0;
              rmh_nxt = 1'b1;
              emit_nxt = 1'b1;
              dleft_nxt = match_r;
              occ_nxt = fill_r - match_r;
              state_nxt = ST_CP_RD;
            end
          end
        endcase
      end

      ST_CP_RD: begin
        if (ins_pend_r && ci_r == ins_src_r) begin
          wr_en = 1'b1;
          wr_data = {hdr_r, mis_r, ann_r, h_r};
          wi_nxt = wi_r + CW'(1);
          ins_pend_nxt = 1'b0;
        end else if (ci_r < fill_r) begin
          rd_en = 1'b1;
          rd_addr = ci_r[AW-1:0];
          state_nxt = ST_CP_WR;
        end else begin
          cur_nxt = !cur_r;
          fill_nxt = occ_r;
          state_nxt = has_fin_r ? ST_FINAL : ST_IDLE;
        end
      end

      ST_CP_WR: begin
        if (drop && emit_r) begin
          if (!out_valid_r || out_ready) begin
            out_valid_nxt = 1'b1;
            out_nxt.kind = rmh_r ? K_REMOVED : K_DROPPED;
            out_nxt.out_handle = 8'(dh);
            out_nxt.occupancy = 5'(occ_r);
            out_nxt.last = !has_fin_r && (dleft_r == CW'(1));
            dleft_nxt = dleft_r - CW'(1);
            ci_nxt = ci_r + CW'(1);
            state_nxt = ST_CP_RD;
          end
        end else begin
          if (!drop) begin
            wr_en = 1'b1;
            wi_nxt = wi_r + CW'(1);
          end
          ci_nxt = ci_r + CW'(1);
          state_nxt = ST_CP_RD;
        end
      end

      ST_FINAL: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt.kind = fin_kind_r;
          out_nxt.out_handle = fin_h_r;
          out_nxt.occupancy = 5'(occ_r);
          out_nxt.last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import copq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 16;
  localparam int WATCH_LIMIT = 20000;
  localparam int IN_W = $bits(in_item_t);

  typedef struct {
    logic [7:0] handle;
    logic       ann;
    logic       mis;
    logic       hdr;
  } entry_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  res_item_t out_data;

  entry_t    queue_model[$];
  res_item_t pending_results[$];
  int        errors;
  int        results_seen;
  int        items_sent;
  int        idle_pct;
  int        hold_off;
  int        quiet_cycles;
  bit        finished;

  class_ordered_packet_queue_unit #(.DEPTH(QDEPTH), .HANDLE_BITS(8)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void push_result(logic [2:0] kind, logic [7:0] h,
                                      ref res_item_t batch[$]);
    res_item_t r;
    r.kind = kind;
    r.out_handle = h;
    r.occupancy = '0;
    r.last = 1'b0;
    batch.insert(batch.size(), r);
  endfunction

  task automatic predict_queue(input in_item_t it);
    res_item_t batch[$];
    entry_t    e;
    int        i;
    int        after;
    bit        found;
    bit        has_ann;
    e.handle = it.handle;
    e.ann = it.is_announce;
    e.mis = it.is_mission;
    e.hdr = it.is_header;
    case (it.func)
      FN_ENQ: begin
        if (e.ann) begin
          has_ann = 0;
          foreach (queue_model[k]) if (queue_model[k].ann) has_ann = 1;
          if (has_ann) push_result(K_DISCARDED, e.handle, batch);
          else if (queue_model.size() >= QDEPTH) push_result(K_FULL, e.handle, batch);
          else begin
            for (i = 0; i < queue_model.size(); i++) if (queue_model[i].hdr) break;
            queue_model.insert(i, e);
            push_result(K_ENQUEUED, e.handle, batch);
          end
        end else if (e.mis) begin
          if (queue_model.size() >= QDEPTH) push_result(K_FULL, e.handle, batch);
          else begin
            queue_model.insert(queue_model.size(), e);
            push_result(K_ENQUEUED, e.handle, batch);
          end
        end else if (e.hdr) begin
          for (i = 0; i < queue_model.size(); i++)
            if (!queue_model[i].mis && queue_model[i].hdr) break;
          if (i < queue_model.size()) begin
            while (i < queue_model.size() && !queue_model[i].mis) begin
              push_result(K_DROPPED, queue_model[i].handle, batch);
              queue_model.delete(i);
            end
            queue_model.insert(i, e);
            push_result(K_ENQUEUED, e.handle, batch);
          end else if (queue_model.size() >= QDEPTH) push_result(K_FULL, e.handle, batch);
          else begin
            queue_model.insert(queue_model.size(), e);
            push_result(K_ENQUEUED, e.handle, batch);
          end
        end else begin
          if (queue_model.size() >= QDEPTH) push_result(K_FULL, e.handle, batch);
          else begin
            found = 0;
            after = 0;
            for (i = 0; i < queue_model.size(); i++) begin
              if (!queue_model[i].mis && queue_model[i].hdr) begin
                found = 1;
                after = i;
              end else if (found && !queue_model[i].mis) after = i;
            end
            queue_model.insert(found ? after + 1 : 0, e);
            push_result(K_ENQUEUED, e.handle, batch);
          end
        end
      end
      FN_DEQ: begin
        if (queue_model.size() == 0) push_result(K_EMPTY, 8'd0, batch);
        else begin
          push_result(K_DEQUEUED, queue_model[0].handle, batch);
          queue_model.delete(0);
        end
      end
      FN_RMPOS: begin
        if (it.position >= queue_model.size()) push_result(K_IGNORED, 8'd0, batch);
        else begin
          push_result(K_REMOVED, queue_model[it.position].handle, batch);
          queue_model.delete(it.position);
        end
      end
      default: begin
        i = 0;
        while (i < queue_model.size()) begin
          if (queue_model[i].handle == it.handle) begin
            push_result(K_REMOVED, it.handle, batch);
            queue_model.delete(i);
          end else i++;
        end
        if (batch.size() == 0) push_result(K_IGNORED, it.handle, batch);
      end
    endcase
    foreach (batch[k]) begin
      batch[k].occupancy = 5'(queue_model.size());
      batch[k].last = (k == batch.size() - 1);
      pending_results.insert(pending_results.size(), batch[k]);
    end
  endtask

  task automatic send_item(input in_item_t it, input bit may_idle = 1);
    while (may_idle && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_queue(it);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic in_item_t make_item(logic [1:0] fn, logic [7:0] h, bit a, bit m,
                                         bit hd, logic [3:0] p);
    in_item_t it;
    it.func = fn;
    it.handle = h;
    it.is_announce = a;
    it.is_mission = m;
    it.is_header = hd;
    it.position = p;
    return it;
  endfunction

  function automatic in_item_t random_item(int pool);
    in_item_t it;
    int r;
    it = in_item_t'(IN_W'($urandom));
    r = $urandom_range(99);
    if (r < 60) it.func = FN_ENQ;
    else if (r < 75) it.func = FN_DEQ;
    else if (r < 88) it.func = FN_RMPOS;
    else it.func = FN_RMH;
    if (pool > 0 && $urandom_range(3) != 0) it.handle = 8'($urandom_range(pool - 1));
    if ($urandom_range(3) != 0) it.is_announce = ($urandom_range(9) == 0);
    return it;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, out_data);
        errors++;
      end else begin
        res_item_t want;
        want = pending_results[0];
        pending_results.delete(0);
        if (want.kind !== out_data.kind)
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_data.kind);
        if (want.out_handle !== out_data.out_handle)
          $display("%0t: handle expected %0d actual %0d", $time, want.out_handle,
                   out_data.out_handle);
        if (want.occupancy !== out_data.occupancy)
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                   out_data.occupancy);
        if (want.last !== out_data.last)
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_data.last);
        if (want !== out_data) errors++;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCH_LIMIT && !finished) begin
      $display("FAIL class_ordered_packet_queue_unit");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(make_item(FN_DEQ, 8'd0, 0, 0, 0, 4'd0));
    send_item(make_item(FN_RMPOS, 8'd0, 0, 0, 0, 4'd15));
    send_item(make_item(FN_RMH, 8'hFF, 0, 0, 0, 4'd0));
    send_item(make_item(FN_ENQ, 8'd1, 0, 1, 0, 4'd0));
    send_item(make_item(FN_ENQ, 8'd2, 0, 0, 0, 4'd0));
    send_item(make_item(FN_ENQ, 8'd3, 0, 0, 1, 4'd0));
    send_item(make_item(FN_ENQ, 8'd4, 0, 0, 0, 4'd0));
    send_item(make_item(FN_ENQ, 8'd5, 0, 0, 0, 4'd0));
    send_item(make_item(FN_ENQ, 8'd6, 0, 1, 1, 4'd0));
    send_item(make_item(FN_ENQ, 8'd7, 1, 0, 0, 4'd0));
    send_item(make_item(FN_ENQ, 8'd8, 1, 1, 1, 4'd0));
    send_item(make_item(FN_ENQ, 8'd9, 0, 0, 1, 4'd0));
    send_item(make_item(FN_ENQ, 8'hFF, 0, 0, 0, 4'd0));
    send_item(make_item(FN_ENQ, 8'hFF, 0, 1, 0, 4'd0));
    send_item(make_item(FN_RMH, 8'hFF, 0, 0, 0, 4'd0));
    send_item(make_item(FN_RMPOS, 8'd0, 0, 0, 0, 4'd1));
    send_item(make_item(FN_DEQ, 8'd0, 0, 0, 0, 4'd0));
    wait_drained();
  endtask

  task automatic test_fill_and_stall();
    hold_off = 400;
    for (int i = 0; i < 18; i++) send_item(make_item(FN_ENQ, 8'(i), 0, 1, 0, 4'd0), 0);
    send_item(make_item(FN_ENQ, 8'h80, 1, 0, 0, 4'd0));
    send_item(make_item(FN_ENQ, 8'h81, 0, 0, 0, 4'd0));
    send_item(make_item(FN_RMPOS, 8'd0, 0, 0, 0, 4'd15));
    send_item(make_item(FN_RMPOS, 8'd0, 0, 0, 0, 4'd15));
    wait_drained();
    for (int i = 0; i < 16; i++) send_item(make_item(FN_ENQ, 8'h40, 0, 0, 0, 4'd0));
    send_item(make_item(FN_ENQ, 8'h41, 0, 0, 1, 4'd0));
    send_item(make_item(FN_RMH, 8'h40, 0, 0, 0, 4'd0));
    wait_drained();
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++) send_item(random_item((i % 50 < 25) ? 6 : 0));
    wait_drained();
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    items_sent = 0;
    idle_pct = 11;
    hold_off = 0;
    finished = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fill_and_stall();
    test_random(120, 11);
    test_random(50, 0);
    test_random(80, 11);
    finished = 1;
    $display("Sent %0d items, checked %0d results: class placement, replacement,",
             items_sent, results_seen);
    $display("full queue, dequeue and both removal kinds under random stalls.");
    if (errors == 0) begin
      $display("PASS class_ordered_packet_queue_unit");
    end else begin
      $display("FAIL class_ordered_packet_queue_unit");
    end
    $finish;
  end
endmodule
